FILE: rtl/tsf_pkg.sv
`default_nettype none
package tsf_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int MAX_SHIFT   = 4;

    localparam int SHIFT_W  = 3;
    localparam int LIMIT_W  = 12;
    localparam int CNT_W    = 5;
    localparam int GAIN_W   = 4;
    localparam int ACC_BITS = SAMPLE_BITS + MAX_SHIFT + 1;
    localparam int PROD_W   = ACC_BITS + GAIN_W;
    localparam int OUT_W    = 15;
    localparam int CFG_W    = 12;

    // quotient bits retired per divider cycle; PROD_W is a multiple of it
    localparam int DIV_STEP  = 7;
    localparam int DIV_ITERS = (PROD_W + DIV_STEP - 1) / DIV_STEP;
    localparam int ITER_W    = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;
    localparam int DIV_LANES = 2;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 2;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    typedef enum logic [1:0] {
        CFG_CHANGE_LIMIT     = 2'd0,
        CFG_SMOOTHING_SHIFT  = 2'd1,
        CFG_OUTPUT_THRESHOLD = 2'd2,
        CFG_FILTER_GAIN      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [LIMIT_W-1:0] change_limit;
        logic [SHIFT_W-1:0] smoothing_shift;
        logic [CNT_W-1:0]   output_threshold;
        logic [GAIN_W-1:0]  filter_gain;
    } t_cfg;

    typedef struct packed {
        logic load_in;
        logic eval;
        logic div_start;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic need_avg;
        logic div_done;
    } t_sts;

endpackage
`default_nettype wire

FILE: rtl/tsf_div.sv
`default_nettype none
module tsf_div (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_start,
    input  logic [tsf_pkg::DIV_LANES-1:0][tsf_pkg::PROD_W-1:0] i_dividend,
    input  logic [tsf_pkg::CNT_W-1:0]                 i_divisor,
    output logic [tsf_pkg::DIV_LANES-1:0][tsf_pkg::PROD_W-1:0] o_quot,
    output logic                                      o_done
);
    import tsf_pkg::*;

    logic [DIV_LANES-1:0][PROD_W-1:0] r_q;
    logic [DIV_LANES-1:0][PROD_W-1:0] n_q;
    logic [DIV_LANES-1:0][CNT_W-1:0]  r_rem;
    logic [DIV_LANES-1:0][CNT_W-1:0]  n_rem;
    logic [CNT_W-1:0]                 r_div;
    logic [ITER_W-1:0]                r_iter;
    logic                             r_busy;

    // restoring division, DIV_STEP quotient bits per cycle
    for (genvar g = 0; g < DIV_LANES; g++) begin : g_lane
        always_comb begin
            logic [CNT_W:0]    rt;
            logic [CNT_W-1:0]  rm;
            logic [PROD_W-1:0] qq;
            rm = r_rem[g];
            qq = r_q[g];
            rt = '0;
            for (int k = 0; k < DIV_STEP; k++) begin
                rt = {rm, qq[PROD_W-1]};
                qq = {qq[PROD_W-2:0], 1'b0};
                if (rt >= {1'b0, r_div}) begin
                    rt    = rt - {1'b0, r_div};
                    qq[0] = 1'b1;
                end
                rm = rt[CNT_W-1:0];
            end
            n_q[g]   = qq;
            n_rem[g] = rm;
        end
    end

    assign o_done = r_busy && (r_iter == ITER_W'(DIV_ITERS - 1));
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_iter <= '0;
        end else if (r_busy) begin
            r_iter <= r_iter + ITER_W'(1);
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/tsf_datapath.sv
`default_nettype none
module tsf_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tsf_pkg::t_cfg                 i_cfg,
    input  tsf_pkg::t_cmd                 i_cmd,
    output tsf_pkg::t_sts                 o_sts,
    input  logic [tsf_pkg::SAMPLE_BITS-1:0] i_sample_x,
    input  logic [tsf_pkg::SAMPLE_BITS-1:0] i_sample_y,
    input  logic                          i_pen_down,
    output logic                          o_keep,
    output logic [tsf_pkg::OUT_W-1:0]     o_out_x,
    output logic [tsf_pkg::OUT_W-1:0]     o_out_y,
    output logic                          o_pen_state
);
    import tsf_pkg::*;

    logic [SAMPLE_BITS-1:0] r_in_x, r_in_y;
    logic                   r_in_pen;

    logic                   r_pen_was_down;
    logic                   r_have_ref;
    logic [SAMPLE_BITS-1:0] r_ref_x, r_ref_y;
    logic                   r_skip;
    logic [ACC_BITS-1:0]    r_acc_x, r_acc_y;
    logic [CNT_W-1:0]       r_cnt;
    logic [OUT_W-1:0]       r_held_x, r_held_y;

    logic                   r_res_keep;
    logic                   r_res_held;
    logic                   r_res_pen;
    logic                   r_avg;

    logic                   r_out_keep, r_out_pen;
    logic [OUT_W-1:0]       r_out_x, r_out_y;

    logic                   rise, fall, jump, take;
    logic [SAMPLE_BITS-1:0] dx, dy;
    logic [SHIFT_W-1:0]     shift_eff;
    logic [CNT_W-1:0]       depth, cnt_l, new_cnt;
    logic                   leak;
    logic [ACC_BITS-1:0]    acc_lx, acc_ly, new_acc_x, new_acc_y;

    logic [DIV_LANES-1:0][PROD_W-1:0] prod;
    logic [DIV_LANES-1:0][PROD_W-1:0] quot;
    logic [OUT_W-1:0]       avg_x, avg_y, sel_x, sel_y;
    logic                   div_done;

    assign rise = r_in_pen && !r_pen_was_down;
    assign fall = !r_in_pen && r_pen_was_down;

    assign dx = (r_in_x > r_ref_x) ? r_in_x - r_ref_x : r_ref_x - r_in_x;
    assign dy = (r_in_y > r_ref_y) ? r_in_y - r_ref_y : r_ref_y - r_in_y;
    assign jump = r_have_ref && ((dx > i_cfg.change_limit) || (dy > i_cfg.change_limit));
    assign take = !rise && !fall && !r_skip && !jump;

    assign shift_eff = (i_cfg.smoothing_shift > SHIFT_W'(MAX_SHIFT)) ?
                       SHIFT_W'(MAX_SHIFT) : i_cfg.smoothing_shift;
    assign depth     = CNT_W'(1) << shift_eff;
    assign leak      = r_cnt >= depth;
    assign acc_lx    = leak ? r_acc_x - (r_acc_x >> shift_eff) : r_acc_x;
    assign acc_ly    = leak ? r_acc_y - (r_acc_y >> shift_eff) : r_acc_y;
    assign cnt_l     = leak ? depth - CNT_W'(1) : r_cnt;
    assign new_acc_x = acc_lx + ACC_BITS'(r_in_x);
    assign new_acc_y = acc_ly + ACC_BITS'(r_in_y);
    assign new_cnt   = cnt_l + CNT_W'(1);

    assign o_sts.need_avg = take && (new_cnt > i_cfg.output_threshold);
    assign o_sts.div_done = div_done;

    assign prod[0] = PROD_W'(r_acc_x) * PROD_W'(i_cfg.filter_gain);
    assign prod[1] = PROD_W'(r_acc_y) * PROD_W'(i_cfg.filter_gain);

    tsf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (prod),
        .i_divisor  (r_cnt),
        .o_quot     (quot),
        .o_done     (div_done)
    );

    assign avg_x = (|quot[0][PROD_W-1:OUT_W]) ? OUT_MAX : quot[0][OUT_W-1:0];
    assign avg_y = (|quot[1][PROD_W-1:OUT_W]) ? OUT_MAX : quot[1][OUT_W-1:0];

    always_comb begin
        priority if (r_avg) begin
            sel_x = avg_x;
            sel_y = avg_y;
        end else if (r_res_held) begin
            sel_x = r_held_x;
            sel_y = r_held_y;
        end else begin
            sel_x = '0;
            sel_y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_x   <= i_sample_x;
            r_in_y   <= i_sample_y;
            r_in_pen <= i_pen_down;
        end
        if (i_cmd.eval) begin
            r_res_pen <= r_in_pen;
        end
        if (i_cmd.load_out) begin
            r_out_keep <= r_res_keep;
            r_out_pen  <= r_res_pen;
            r_out_x    <= sel_x;
            r_out_y    <= sel_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_was_down <= 1'b0;
            r_have_ref     <= 1'b0;
            r_ref_x        <= '0;
            r_ref_y        <= '0;
            r_skip         <= 1'b0;
            r_acc_x        <= '0;
            r_acc_y        <= '0;
            r_cnt          <= '0;
            r_held_x       <= '0;
            r_held_y       <= '0;
            r_res_keep     <= 1'b0;
            r_res_held     <= 1'b0;
            r_avg          <= 1'b0;
        end else begin
            if (i_cmd.eval) begin
                r_res_keep <= fall || o_sts.need_avg;
                r_res_held <= fall;
                r_avg      <= o_sts.need_avg;
                priority if (rise) begin
                    r_have_ref     <= 1'b0;
                    r_cnt          <= '0;
                    r_acc_x        <= '0;
                    r_acc_y        <= '0;
                    r_skip         <= 1'b1;
                    r_pen_was_down <= 1'b1;
                end else if (fall) begin
                    r_pen_was_down <= 1'b0;
                end else if (r_skip) begin
                    r_skip <= 1'b0;
                end else if (take) begin
                    r_ref_x    <= r_in_x;
                    r_ref_y    <= r_in_y;
                    r_have_ref <= 1'b1;
                    r_acc_x    <= new_acc_x;
                    r_acc_y    <= new_acc_y;
                    r_cnt      <= new_cnt;
                end else begin
                    r_have_ref <= r_have_ref;
                end
            end
            if (i_cmd.load_out && r_avg) begin
                r_held_x <= avg_x;
                r_held_y <= avg_y;
            end
        end
    end

    assign o_keep      = r_out_keep;
    assign o_pen_state = r_out_pen;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;

endmodule
`default_nettype wire

FILE: rtl/tsf_ctrl.sv
`default_nettype none
module tsf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tsf_pkg::t_cmd o_cmd,
    input  tsf_pkg::t_sts i_sts
);
    import tsf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVAL  = 5'b00010,
        S_START = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.need_avg ? S_START : S_DONE;
            end
            S_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        priority if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

FILE: rtl/touch_sample_filter.sv
`default_nettype none
// Channel   Dir  Handshake                     Content
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: sample_x, sample_y; tuser: pen_down
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: out_x, out_y; tuser: keep, pen_state
// cfg       in   i_cfg_we (no wait)            i_cfg_idx, i_cfg_data
//
// One beat at a time: edge, skipped, dropped or below-threshold samples go from
// accept through eval to the output load; when an average is formed, a start
// state and the divider, retiring 7 quotient bits per cycle, come in between.
// A new beat is taken only after the previous one is loaded for output.
// The next beat is taken while the previous result waits on m_axis.
// Synchronous active-low reset restores the register defaults and clears
// the limiter and filter state. m_axis stalls hold the block in its final
// state until the output register frees up.
module touch_sample_filter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [11:0] sample_x, [23:12] sample_y
    input  logic [tsf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] pen_down
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [14:0] out_x, [29:15] out_y, [31:30] zero
    output logic [tsf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [0] keep, [1] pen_state
    output logic [tsf_pkg::OUT_USER_W-1:0]     m_axis_tuser,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_idx,
    input  logic [tsf_pkg::CFG_W-1:0]          i_cfg_data
);
    import tsf_pkg::*;

    t_cfg             r_cfg;
    t_cmd             cmd;
    t_sts             sts;
    logic             keep, pen_state;
    logic [OUT_W-1:0] out_x, out_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.change_limit     <= LIMIT_W'(360);
            r_cfg.smoothing_shift  <= SHIFT_W'(2);
            r_cfg.output_threshold <= CNT_W'(1);
            r_cfg.filter_gain      <= GAIN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CHANGE_LIMIT:     r_cfg.change_limit     <= i_cfg_data[LIMIT_W-1:0];
                CFG_SMOOTHING_SHIFT:  r_cfg.smoothing_shift  <= i_cfg_data[SHIFT_W-1:0];
                CFG_OUTPUT_THRESHOLD: r_cfg.output_threshold <= i_cfg_data[CNT_W-1:0];
                CFG_FILTER_GAIN:      r_cfg.filter_gain      <= i_cfg_data[GAIN_W-1:0];
                default:              r_cfg <= r_cfg;
            endcase
        end
    end

    tsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    tsf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_sample_x  (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_sample_y  (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_pen_down  (s_axis_tuser),
        .o_keep      (keep),
        .o_out_x     (out_x),
        .o_out_y     (out_y),
        .o_pen_state (pen_state)
    );

    assign m_axis_tdata = {(OUT_DATA_W - 2*OUT_W)'(0), out_y, out_x};
    assign m_axis_tuser = {pen_state, keep};

endmodule
`default_nettype wire

FILE: rtl/tsf_checker.sv
`default_nettype none
module tsf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a held result never changes under backpressure
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // dropped samples carry a zero position
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[29:0] == 30'd0)
        else $error("dropped beat with nonzero position");

    // pad bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:30] == 2'd0)
        else $error("tdata pad bits set");

    // one sample in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second beat taken while busy");

endmodule

bind touch_sample_filter tsf_checker u_tsf_checker (.*);
`default_nettype wire

FILE: tb/touch_sample_filter_tb.sv
`default_nettype none
module touch_sample_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;

    typedef struct packed {
        logic                   keep;
        logic [OUT_W-1:0]       pos_x;
        logic [OUT_W-1:0]       pos_y;
        logic                   pen_state;
    } t_pos_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic                    s_axis_tuser = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic [OUT_USER_W-1:0]   m_axis_tuser;
    logic                    i_cfg_we = 1'b0;
    logic [1:0]              i_cfg_idx = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;

    touch_sample_filter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // filter model: register copies
    logic [LIMIT_W-1:0]     lim_cfg    = 12'd360;
    logic [SHIFT_W-1:0]     shift_cfg  = 3'd2;
    logic [CNT_W-1:0]       thresh_cfg = 5'd1;
    logic [GAIN_W-1:0]      gain_cfg   = 4'd1;

    // filter model: stroke state
    logic                   pen_held  = 1'b0;
    logic                   ref_valid = 1'b0;
    logic [SAMPLE_BITS-1:0] ref_x = '0;
    logic [SAMPLE_BITS-1:0] ref_y = '0;
    logic                   skip_next = 1'b0;
    logic [ACC_BITS-1:0]    acc_x = '0;
    logic [ACC_BITS-1:0]    acc_y = '0;
    logic [CNT_W-1:0]       acc_cnt = '0;
    logic [OUT_W-1:0]       last_x = '0;
    logic [OUT_W-1:0]       last_y = '0;

    t_pos_result expected_pos_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int n_sent         = 0;
    int n_checked      = 0;
    int n_kept         = 0;
    int n_saturated    = 0;
    int n_cfg_writes   = 0;
    int idle_cycles    = 0;

    function automatic logic jump_too_far(input logic [SAMPLE_BITS-1:0] a,
                                          input logic [SAMPLE_BITS-1:0] b);
        int d;
        d = int'(a) - int'(b);
        if (d < 0) d = -d;
        return d > int'(lim_cfg);
    endfunction

    function automatic logic [OUT_W-1:0] scaled_mean(input logic [ACC_BITS-1:0] acc);
        longint unsigned q;
        q = (longint'(acc) * longint'(gain_cfg)) / longint'(acc_cnt);
        return (q > longint'(OUT_MAX)) ? OUT_MAX : q[OUT_W-1:0];
    endfunction

    function automatic t_pos_result filter_sample(input logic [SAMPLE_BITS-1:0] x,
                                                  input logic [SAMPLE_BITS-1:0] y,
                                                  input logic pen);
        t_pos_result r;
        int sh;
        int depth;
        r = '{keep: 1'b0, pos_x: '0, pos_y: '0, pen_state: pen};
        if (pen && !pen_held) begin
            ref_valid = 1'b0;
            acc_cnt   = '0;
            acc_x     = '0;
            acc_y     = '0;
            skip_next = 1'b1;
            pen_held  = 1'b1;
            return r;
        end
        if (!pen && pen_held) begin
            pen_held = 1'b0;
            r.keep   = 1'b1;
            r.pos_x  = last_x;
            r.pos_y  = last_y;
            return r;
        end
        if (skip_next) begin
            skip_next = 1'b0;
            return r;
        end
        if (ref_valid && (jump_too_far(x, ref_x) || jump_too_far(y, ref_y)))
            return r;
        ref_x     = x;
        ref_y     = y;
        ref_valid = 1'b1;
        sh    = (shift_cfg > MAX_SHIFT) ? MAX_SHIFT : int'(shift_cfg);
        depth = 1 << sh;
        if (int'(acc_cnt) >= depth) begin
            acc_x   = acc_x - (acc_x >> sh);
            acc_y   = acc_y - (acc_y >> sh);
            acc_cnt = CNT_W'(depth - 1);
        end
        acc_x   = acc_x + ACC_BITS'(x);
        acc_y   = acc_y + ACC_BITS'(y);
        acc_cnt = acc_cnt + CNT_W'(1);
        if (acc_cnt <= thresh_cfg)
            return r;
        last_x  = scaled_mean(acc_x);
        last_y  = scaled_mean(acc_y);
        r.keep  = 1'b1;
        r.pos_x = last_x;
        r.pos_y = last_y;
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // result checker and receiver stalls
    always @(posedge i_clk) begin : chk
        t_pos_result got;
        t_pos_result want;
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.keep      = m_axis_tuser[0];
            got.pen_state = m_axis_tuser[1];
            got.pos_x     = m_axis_tdata[OUT_W-1:0];
            got.pos_y     = m_axis_tdata[2*OUT_W-1:OUT_W];
            n_checked++;
            if (expected_pos_q.size() == 0) begin
                note_mismatch($sformatf("unexpected beat keep=%0b x=%0d y=%0d pen=%0b",
                              got.keep, got.pos_x, got.pos_y, got.pen_state));
            end else begin
                want = expected_pos_q.pop_front();
                if (want.keep) n_kept++;
                if (want.keep && (want.pos_x == OUT_MAX || want.pos_y == OUT_MAX))
                    n_saturated++;
                if (got.keep !== want.keep || got.pos_x !== want.pos_x ||
                    got.pos_y !== want.pos_y || got.pen_state !== want.pen_state)
                    note_mismatch($sformatf({"result %0d: exp keep=%0b x=%0d y=%0d pen=%0b",
                                  " got keep=%0b x=%0d y=%0d pen=%0b"}, n_checked,
                                  want.keep, want.pos_x, want.pos_y, want.pen_state,
                                  got.keep, got.pos_x, got.pos_y, got.pen_state));
            end
        end
    end

    // stall watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("touch_sample_filter test failed");
            $finish;
        end
    end

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] x,
                               input logic [SAMPLE_BITS-1:0] y,
                               input logic pen);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tuser  <= pen;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_pos_q.push_back(filter_sample(x, y, pen));
        n_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_pos_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // writes all four registers back to back; block must be idle
    task automatic set_config(input logic [LIMIT_W-1:0] lim, input logic [SHIFT_W-1:0] sh,
                              input logic [CNT_W-1:0] th, input logic [GAIN_W-1:0] gain);
        t_cfg_idx idx;
        for (int i = 0; i < 4; i++) begin
            idx = t_cfg_idx'(i);
            i_cfg_we  <= 1'b1;
            i_cfg_idx <= idx;
            case (idx)
                CFG_CHANGE_LIMIT:     i_cfg_data <= CFG_W'(lim);
                CFG_SMOOTHING_SHIFT:  i_cfg_data <= CFG_W'(sh);
                CFG_OUTPUT_THRESHOLD: i_cfg_data <= CFG_W'(th);
                default:              i_cfg_data <= CFG_W'(gain);
            endcase
            @(posedge i_clk);
            case (idx)
                CFG_CHANGE_LIMIT:     lim_cfg    = lim;
                CFG_SMOOTHING_SHIFT:  shift_cfg  = sh;
                CFG_OUTPUT_THRESHOLD: thresh_cfg = th;
                default:              gain_cfg   = gain;
            endcase
            n_cfg_writes++;
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic randomize_config();
        logic [LIMIT_W-1:0] lim;
        logic [CNT_W-1:0]   th;
        logic [GAIN_W-1:0]  gain;
        case ($urandom_range(0, 9))
            0:       lim = '0;
            1:       lim = '1;
            2:       lim = LIMIT_W'($urandom_range(0, 4095));
            default: lim = LIMIT_W'($urandom_range(0, 600));
        endcase
        th   = ($urandom_range(0, 9) < 8) ? CNT_W'($urandom_range(0, 4)) :
                                            CNT_W'($urandom_range(0, 31));
        gain = ($urandom_range(0, 9) < 8) ? GAIN_W'($urandom_range(1, 8)) :
                                            GAIN_W'($urandom_range(0, 15));
        drain_results();
        set_config(lim, SHIFT_W'($urandom_range(0, 7)), th, gain);
    endtask

    // register defaults: pen up while up, jumps, pen edges
    task automatic test_default_config();
        send_sample(12'd0, 12'd0, 1'b0);
        send_sample(12'd4095, 12'd4095, 1'b0);
        send_sample(12'd0, 12'd0, 1'b1);
        send_sample(12'd100, 12'd200, 1'b1);
        send_sample(12'd4095, 12'd0, 1'b1);
        send_sample(12'd4095, 12'd0, 1'b1);
        send_sample(12'd4000, 12'd100, 1'b1);
        send_sample(12'd3000, 12'd100, 1'b1);
        send_sample(12'd4000, 12'd600, 1'b1);
        send_sample(12'd3800, 12'd300, 1'b1);
        send_sample(12'd0, 12'd0, 1'b0);
    endtask

    // saturation, zero gain, shift clamp, unreachable threshold, shift lowered mid-stroke
    task automatic test_config_extremes();
        drain_results();
        set_config(12'd4095, 3'd0, 5'd0, 4'd15);
        send_sample(12'd4095, 12'd4095, 1'b1);
        send_sample(12'd0, 12'd0, 1'b1);
        send_sample(12'd4095, 12'd4095, 1'b1);
        send_sample(12'd0, 12'd0, 1'b1);
        drain_results();
        set_config(12'd0, 3'd0, 5'd0, 4'd0);
        send_sample(12'd0, 12'd4095, 1'b1);
        send_sample(12'd0, 12'd0, 1'b1);
        drain_results();
        set_config(12'd4095, 3'd7, 5'd16, 4'd8);
        repeat (3) send_sample(12'd4095, 12'd4095, 1'b1);
        drain_results();
        set_config(12'd4095, 3'd1, 5'd0, 4'd8);
        send_sample(12'd2048, 12'd1024, 1'b1);
        send_sample(12'd4095, 12'd4095, 1'b1);
        send_sample(12'd123, 12'd456, 1'b0);
    endtask

    // strokes of nearby samples with random content, mixed with noise
    task automatic test_random_strokes(input int idle_pct, input int stall_pct,
                                       input int n_items);
        int start;
        int len;
        int r;
        int cx;
        int cy;
        start = n_sent;
        drain_results();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (n_sent - start < n_items) begin
            if ($urandom_range(0, 5) == 0)
                randomize_config();
            if ($urandom_range(0, 9) < 8) begin
                cx  = int'($urandom_range(0, 4095));
                cy  = int'($urandom_range(0, 4095));
                len = int'($urandom_range(1, 30));
                send_sample(SAMPLE_BITS'(cx), SAMPLE_BITS'(cy), 1'b1);
                for (int i = 0; i < len; i++) begin
                    r = (lim_cfg < 300) ? int'(lim_cfg) + 20 : 320;
                    if ($urandom_range(0, 9) == 0) begin
                        cx = int'($urandom_range(0, 4095));
                        cy = int'($urandom_range(0, 4095));
                    end else begin
                        cx = cx + int'($urandom_range(0, 2 * r)) - r;
                        cy = cy + int'($urandom_range(0, 2 * r)) - r;
                        cx = (cx < 0) ? 0 : (cx > 4095) ? 4095 : cx;
                        cy = (cy < 0) ? 0 : (cy > 4095) ? 4095 : cy;
                    end
                    send_sample(SAMPLE_BITS'(cx), SAMPLE_BITS'(cy), 1'b1);
                    if ($urandom_range(0, 59) == 0)
                        drain_results();
                end
                send_sample(SAMPLE_BITS'($urandom_range(0, 4095)),
                            SAMPLE_BITS'($urandom_range(0, 4095)), 1'b0);
            end else begin
                repeat ($urandom_range(1, 5))
                    send_sample(SAMPLE_BITS'($urandom_range(0, 4095)),
                                SAMPLE_BITS'($urandom_range(0, 4095)),
                                1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_config();
        test_config_extremes();
        test_random_strokes(0, 0, 310);
        test_random_strokes(82, 0, 310);
        test_random_strokes(0, 82, 310);
        test_random_strokes(29, 29, 310);

        drain_results();
        repeat (20) @(posedge i_clk);

        $display("Covered %0d samples, %0d results checked (%0d positions, %0d saturated),",
                 n_sent, n_checked, n_kept, n_saturated);
        $display("%0d register writes over four stall/idle mixes.", n_cfg_writes);
        if (mismatches == 0) begin
            $display("touch_sample_filter test passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("touch_sample_filter test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
